// ===== rtl/core/aes_rnd_pkg.sv =====
// Shared types, constants and byte functions for the AES encryption round core.
// Holds the S-box table and GF(2^8) doubling; depends on nothing else.
package aes_rnd_pkg;

  localparam int COLUMNS = 4;
  localparam int ROWS    = 4;

  typedef logic [7:0]                 byte_t;
  typedef logic [ROWS*8-1:0]          word_t;
  // Row 0 sits in the top byte of a column.
  typedef logic [0:ROWS-1][7:0]       col_t;
  typedef logic [0:COLUMNS*ROWS-1][7:0] state_t;
  typedef logic [0:COLUMNS-1][ROWS*8-1:0] words_t;

  // Handshake status between the output stage and the front stage.
  typedef struct packed {
    logic stage_valid;
    logic can_load;
  } stage_ctrl_t;

  localparam byte_t POLY_LOW = 8'h1b;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t sub_byte(input byte_t b);
    return SBOX[b];
  endfunction

  // Multiply by x modulo the AES field polynomial.
  function automatic byte_t gf_double(input byte_t b);
    byte_t r;
    r = {b[6:0], 1'b0};
    if (b[7]) begin
      r = r ^ POLY_LOW;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/aes_rnd_lane.sv =====
// One column lane: S-box stage register, then MixColumns and round-key add.
// Depends on aes_rnd_pkg for the S-box, GF doubling and column types.
module aes_rnd_lane (
  input  logic               clk,
  input  logic               load,
  input  aes_rnd_pkg::col_t  col_in,
  input  aes_rnd_pkg::word_t key_in,
  output aes_rnd_pkg::word_t word_out
);

  aes_rnd_pkg::col_t  sub;
  aes_rnd_pkg::word_t key_q;
  aes_rnd_pkg::col_t  mix;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int r = 0; r < aes_rnd_pkg::ROWS; r++) begin
        sub[r] <= aes_rnd_pkg::sub_byte(col_in[r]);
      end
      key_q <= key_in;
    end
  end

  // out_r = 2*a_r ^ 3*a_{r+1} ^ a_{r+2} ^ a_{r+3}
  for (genvar r = 0; r < aes_rnd_pkg::ROWS; r++) begin : g_row
    localparam int R1 = (r + 1) % aes_rnd_pkg::ROWS;
    localparam int R2 = (r + 2) % aes_rnd_pkg::ROWS;
    localparam int R3 = (r + 3) % aes_rnd_pkg::ROWS;
    assign mix[r] = aes_rnd_pkg::gf_double(sub[r]) ^ aes_rnd_pkg::gf_double(sub[R1])
                  ^ sub[R1] ^ sub[R2] ^ sub[R3];
  end

  assign word_out = mix ^ key_q;

endmodule

// ===== rtl/core/aes_rnd_merge.sv =====
// Output stage: gathers the lane words into the result register and holds it
// until taken. Depends on aes_rnd_pkg for the word and control types.
module aes_rnd_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  aes_rnd_pkg::words_t       lane_words,
  input  logic                      stage_valid,
  output aes_rnd_pkg::stage_ctrl_t  ctrl,
  output logic [63:0]               out_upper,
  output logic [63:0]               out_lower,
  output logic                      result_valid,
  input  logic                      result_ready
);

  logic can_load;

  assign can_load = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_load) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && stage_valid) begin
      out_upper <= {lane_words[0], lane_words[1]};
      out_lower <= {lane_words[2], lane_words[3]};
    end
  end

  assign ctrl.stage_valid = result_valid;
  assign ctrl.can_load    = can_load;

endmodule

// ===== rtl/core/aes_encrypt_round_core.sv =====
// Top level of the AES-128 encryption round core (non-final round).
// Uses aes_rnd_pkg, aes_rnd_lane (one per column) and aes_rnd_merge.

// Takes a 128-bit state and round key and returns SubBytes, ShiftRows,
// MixColumns and AddRoundKey applied once. Accepts one transaction per clock
// while state_ready is high. Each result passes two registers on its way out:
// one after the S-box lookups in the four column lanes, one in the output stage
// after MixColumns and the key add. A stalled result holds the output register;
// one more transaction may then wait in the lane registers before state_ready
// drops. No state is kept between transactions, so reset only clears the
// pipeline valid flags.
module aes_encrypt_round_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        state_valid,
  output logic        state_ready,
  input  logic [63:0] state_upper,
  input  logic [63:0] state_lower,
  input  logic [63:0] key_upper,
  input  logic [63:0] key_lower,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [63:0] out_upper,
  output logic [63:0] out_lower
);

  aes_rnd_pkg::state_t     st;
  aes_rnd_pkg::words_t     key_words;
  aes_rnd_pkg::words_t     lane_words;
  aes_rnd_pkg::stage_ctrl_t ctrl;
  logic                    s1_valid;
  logic                    load;

  assign st        = {state_upper, state_lower};
  assign key_words = {key_upper, key_lower};

  assign state_ready = !s1_valid || ctrl.can_load;
  assign load        = state_valid && state_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (state_ready) begin
      s1_valid <= state_valid;
    end
  end

  // ShiftRows is pure wiring: lane c row r takes byte from column (c + r).
  for (genvar c = 0; c < aes_rnd_pkg::COLUMNS; c++) begin : g_lane
    aes_rnd_pkg::col_t col_in;
    for (genvar r = 0; r < aes_rnd_pkg::ROWS; r++) begin : g_row
      localparam int SRC = ((c + r) % aes_rnd_pkg::COLUMNS) * aes_rnd_pkg::ROWS + r;
      assign col_in[r] = st[SRC];
    end

    aes_rnd_lane u_lane (
      .clk      (clk),
      .load     (load),
      .col_in   (col_in),
      .key_in   (key_words[c]),
      .word_out (lane_words[c])
    );
  end

  aes_rnd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .lane_words   (lane_words),
    .stage_valid  (s1_valid),
    .ctrl         (ctrl),
    .out_upper    (out_upper),
    .out_lower    (out_lower),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !s1_valid && !result_valid)
    else $error("pipeline valid flags not cleared by reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !state_ready |-> s1_valid && result_valid && !result_ready)
    else $error("input stalled while pipeline has room");

  a_empty_latency: assert property (@(posedge clk) disable iff (rst)
    load && !s1_valid && !result_valid |=> s1_valid ##1 result_valid)
    else $error("transaction through empty pipeline not delivered in two cycles");

  a_merge_flag: assert property (@(posedge clk) disable iff (rst)
    ctrl.stage_valid == result_valid && ctrl.can_load == (!result_valid || result_ready))
    else $error("output stage status inconsistent");

endmodule

// ===== tb/sv/aes_round_checker.sv =====
`timescale 1ns / 1ps
// Checker for aes_encrypt_round_core: watches both channels, predicts each round
// result from the accepted transaction and compares it field by field.
// Depends on aes_rnd_pkg for the state types and geometry.
module aes_round_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        state_valid,
  input  logic        state_ready,
  input  logic [63:0] state_upper,
  input  logic [63:0] state_lower,
  input  logic [63:0] key_upper,
  input  logic [63:0] key_lower,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [63:0] out_upper,
  input  logic [63:0] out_lower,
  output int          mismatches,
  output int          pending_rounds
);

  localparam aes_rnd_pkg::byte_t FIELD_POLY   = 8'h1b;
  localparam aes_rnd_pkg::byte_t AFFINE_CONST = 8'h63;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
  } round_out_t;

  round_out_t         expected_rounds[$];
  aes_rnd_pkg::byte_t sbox_lut [256];
  int                 fail_count = 0;
  int                 queued = 0;

  assign mismatches     = fail_count;
  assign pending_rounds = queued;

  function automatic aes_rnd_pkg::byte_t times_two(input aes_rnd_pkg::byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? FIELD_POLY : 8'h00);
  endfunction

  function automatic aes_rnd_pkg::byte_t field_mul(input aes_rnd_pkg::byte_t a,
                                                   input aes_rnd_pkg::byte_t b);
    aes_rnd_pkg::byte_t acc;
    aes_rnd_pkg::byte_t x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = times_two(x);
    end
    return acc;
  endfunction

  // Build the S-box from the field inverse (v^254) and the affine map.
  initial begin : build_sbox
    aes_rnd_pkg::byte_t inv;
    aes_rnd_pkg::byte_t rot;
    aes_rnd_pkg::byte_t s;
    for (int v = 0; v < 256; v++) begin
      inv = 8'h01;
      repeat (254) inv = field_mul(inv, aes_rnd_pkg::byte_t'(v));
      s   = inv;
      rot = inv;
      for (int k = 0; k < 4; k++) begin
        rot = {rot[6:0], rot[7]};
        s   = s ^ rot;
      end
      sbox_lut[v] = s ^ AFFINE_CONST;
    end
  end

  function automatic round_out_t predict_round(input logic [63:0] su, input logic [63:0] sl,
                                               input logic [63:0] ku, input logic [63:0] kl);
    aes_rnd_pkg::state_t in_bytes;
    aes_rnd_pkg::state_t shifted;
    aes_rnd_pkg::state_t mixed;
    aes_rnd_pkg::byte_t  a0, a1, a2, a3;
    in_bytes = {su, sl};
    // Substitute and rotate row r left by r columns in one pass.
    for (int c = 0; c < aes_rnd_pkg::COLUMNS; c++) begin
      for (int r = 0; r < aes_rnd_pkg::ROWS; r++) begin
        shifted[c*aes_rnd_pkg::ROWS + r] =
          sbox_lut[in_bytes[((c + r) % aes_rnd_pkg::COLUMNS)*aes_rnd_pkg::ROWS + r]];
      end
    end
    for (int c = 0; c < aes_rnd_pkg::COLUMNS; c++) begin
      for (int r = 0; r < aes_rnd_pkg::ROWS; r++) begin
        a0 = shifted[c*aes_rnd_pkg::ROWS + r];
        a1 = shifted[c*aes_rnd_pkg::ROWS + (r + 1) % aes_rnd_pkg::ROWS];
        a2 = shifted[c*aes_rnd_pkg::ROWS + (r + 2) % aes_rnd_pkg::ROWS];
        a3 = shifted[c*aes_rnd_pkg::ROWS + (r + 3) % aes_rnd_pkg::ROWS];
        mixed[c*aes_rnd_pkg::ROWS + r] = times_two(a0) ^ times_two(a1) ^ a1 ^ a2 ^ a3;
      end
    end
    return round_out_t'(mixed ^ {ku, kl});
  endfunction

  always @(posedge clk) begin : watch
    round_out_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_rounds.size() == 0) begin
          $error("unexpected result: out_upper %h out_lower %h", out_upper, out_lower);
          fail_count++;
        end else begin
          want = expected_rounds.pop_front();
          if (out_upper !== want.upper) begin
            $error("out_upper: expected %h actual %h", want.upper, out_upper);
            fail_count++;
          end
          if (out_lower !== want.lower) begin
            $error("out_lower: expected %h actual %h", want.lower, out_lower);
            fail_count++;
          end
        end
      end
      if (state_valid && state_ready) begin
        expected_rounds.push_back(predict_round(state_upper, state_lower, key_upper, key_lower));
      end
    end
    queued = expected_rounds.size();
  end

endmodule

// ===== tb/sv/tb_aes_encrypt_round_core.sv =====
`timescale 1ns / 1ps
// Top of the AES round core testbench: clock, reset, stimulus and verdict.
// Depends on aes_encrypt_round_core and the aes_round_checker module.
module tb_aes_encrypt_round_core;

  localparam int HALF_PERIOD      = 10;
  localparam int RESET_CYCLES     = 9;
  localparam int RANDOM_PER_PHASE = 530;
  localparam int DRAIN_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT   = 1000;

  localparam logic [7:0] EDGE_BYTES [6] = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h7f, 8'h1b};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        state_valid;
  logic        state_ready;
  logic [63:0] state_upper;
  logic [63:0] state_lower;
  logic [63:0] key_upper;
  logic [63:0] key_lower;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [63:0] out_upper;
  logic [63:0] out_lower;

  int send_idle_pct  = 17;
  int recv_stall_pct = 56;
  int quiet_cycles   = 0;
  int mismatches;
  int pending_rounds;

  aes_encrypt_round_core dut (
    .clk          (clk),
    .rst          (rst),
    .state_valid  (state_valid),
    .state_ready  (state_ready),
    .state_upper  (state_upper),
    .state_lower  (state_lower),
    .key_upper    (key_upper),
    .key_lower    (key_lower),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_upper    (out_upper),
    .out_lower    (out_lower)
  );

  aes_round_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .state_valid    (state_valid),
    .state_ready    (state_ready),
    .state_upper    (state_upper),
    .state_lower    (state_lower),
    .key_upper      (key_upper),
    .key_lower      (key_lower),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .out_upper      (out_upper),
    .out_lower      (out_lower),
    .mismatches     (mismatches),
    .pending_rounds (pending_rounds)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (state_valid && state_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] random_lane();
    logic [63:0] lane;
    logic [7:0]  fill;
    logic [2:0]  pick;
    case ($urandom_range(9))
      0: begin
        for (int i = 0; i < 8; i++) begin
          pick = 3'($urandom_range(5));
          lane[i*8 +: 8] = EDGE_BYTES[pick];
        end
      end
      1: begin
        fill = 8'($urandom_range(255));
        lane = {8{fill}};
      end
      default: lane = {$urandom, $urandom};
    endcase
    return lane;
  endfunction

  function automatic logic [63:0] random_key();
    return ($urandom_range(7) == 0) ? 64'h0 : random_lane();
  endfunction

  // Idle per cycle at the current rate, then hold the transaction until accepted.
  task automatic send_round(input logic [63:0] su, input logic [63:0] sl,
                            input logic [63:0] ku, input logic [63:0] kl);
    while ($urandom_range(99) < send_idle_pct) begin
      state_valid <= 1'b0;
      @(posedge clk);
    end
    state_valid <= 1'b1;
    state_upper <= su;
    state_lower <= sl;
    key_upper   <= ku;
    key_lower   <= kl;
    do @(posedge clk); while (!state_ready);
  endtask

  initial begin
    state_valid <= 1'b0;
    state_upper <= '0;
    state_lower <= '0;
    key_upper   <= '0;
    key_lower   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 17;
          recv_stall_pct = 56;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 17;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (phase == 0) begin
        send_round(64'h0, 64'h0, 64'h0, 64'h0);
        send_round('1, '1, '1, '1);
        send_round('1, '1, 64'h0, 64'h0);
        send_round(64'h0, 64'h0, '1, '1);
        send_round({8{8'haa}}, {8{8'h55}}, {8{8'h55}}, {8{8'haa}});
        send_round({8{8'h80}}, {8{8'h80}}, 64'h0, 64'h0);
        send_round({8{8'h01}}, {8{8'h7f}}, 64'h0123456789abcdef, 64'hfedcba9876543210);
        // Round 1 of the standard AES-128 example.
        send_round(64'h193de3bea0f4e22b, 64'h9ac68d2ae9f84808,
                   64'ha0fafe1788542cb1, 64'h23a339392a6c7605);
        send_round(64'h0123456789abcdef, 64'h0, 64'h0, 64'h0);
        send_round(64'h0, 64'h0123456789abcdef, 64'h0, 64'h0);
        send_round(64'h8000000000000000, 64'h0, 64'h0, 64'h0);
        send_round(64'h0, 64'h00000000000000ff, 64'h0, 64'h1);
      end
      repeat (RANDOM_PER_PHASE) begin
        send_round(random_lane(), random_lane(), random_key(), random_key());
      end
    end
    state_valid <= 1'b0;

    do @(negedge clk); while (pending_rounds != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
